// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker of the color conversion block.
// Needs nothing else; every macro resets its check on an active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hsv2rgb check failed");

// Next-cycle implication: cons must hold in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hsv2rgb check failed");

// Invariant: expr must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("hsv2rgb check failed");

`endif

// ===== hdl/hsv2rgb_pkg.sv =====
// Widths, sector codes, stage payload types and the hue split function
// for the HSV to RGB converter. Depends on nothing.
`default_nettype none

package hsv2rgb_pkg;

    localparam int HUE_W       = 9;
    localparam int FRAC_W      = 9;
    localparam int CHAN_W      = 8;
    localparam int REM_W       = 6;
    localparam int WGT_W       = 16;
    localparam int NUM_W       = 24;
    localparam int HUE_FULL    = 360;
    localparam int SECTOR_DEG  = 60;
    localparam int FRAC_ONE    = 256;
    localparam int WGT_ONE     = FRAC_ONE * SECTOR_DEG;
    localparam int CHAN_MAX    = 255;
    // 255 / (256*256*60) reduces to 17 / 2^18
    localparam int SCALE_MUL   = 17;
    localparam int SCALE_SHIFT = 18;

    // Hue sectors of 60 degrees each
    typedef enum logic [2:0] {
        SECT_RED_YELLOW   = 3'd0,
        SECT_YELLOW_GREEN = 3'd1,
        SECT_GREEN_CYAN   = 3'd2,
        SECT_CYAN_BLUE    = 3'd3,
        SECT_BLUE_MAGENTA = 3'd4,
        SECT_MAGENTA_RED  = 3'd5
    } sector_t;

    typedef struct packed {
        sector_t            sector;
        logic [REM_W-1:0]   rem;
    } hue_pos_t;

    typedef struct packed {
        sector_t            sector;
        logic [REM_W-1:0]   rem;
        logic [FRAC_W-1:0]  sat;
        logic [FRAC_W-1:0]  val;
        logic [CHAN_W-1:0]  alpha;
    } sect_t;

    typedef struct packed {
        logic signed [WGT_W-1:0] w_red;
        logic signed [WGT_W-1:0] w_green;
        logic signed [WGT_W-1:0] w_blue;
        logic [FRAC_W-1:0]       val;
        logic [CHAN_W-1:0]       alpha;
    } wgt_t;

    typedef struct packed {
        logic signed [NUM_W-1:0] n_red;
        logic signed [NUM_W-1:0] n_green;
        logic signed [NUM_W-1:0] n_blue;
        logic [CHAN_W-1:0]       alpha;
    } num_t;

    // Wrap the hue once, then find sector and offset inside it by compares
    function automatic hue_pos_t hue_split(input logic [HUE_W-1:0] hue);
        logic [HUE_W-1:0] h;
        hue_pos_t         res;
        h = (hue >= HUE_W'(HUE_FULL)) ? hue - HUE_W'(HUE_FULL) : hue;
        if (h >= HUE_W'(5 * SECTOR_DEG))
        begin
            res.sector = SECT_MAGENTA_RED;
            h = h - HUE_W'(5 * SECTOR_DEG);
        end
        else if (h >= HUE_W'(4 * SECTOR_DEG))
        begin
            res.sector = SECT_BLUE_MAGENTA;
            h = h - HUE_W'(4 * SECTOR_DEG);
        end
        else if (h >= HUE_W'(3 * SECTOR_DEG))
        begin
            res.sector = SECT_CYAN_BLUE;
            h = h - HUE_W'(3 * SECTOR_DEG);
        end
        else if (h >= HUE_W'(2 * SECTOR_DEG))
        begin
            res.sector = SECT_GREEN_CYAN;
            h = h - HUE_W'(2 * SECTOR_DEG);
        end
        else if (h >= HUE_W'(SECTOR_DEG))
        begin
            res.sector = SECT_YELLOW_GREEN;
            h = h - HUE_W'(SECTOR_DEG);
        end
        else
        begin
            res.sector = SECT_RED_YELLOW;
        end
        res.rem = h[REM_W-1:0];
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/hsv2rgb_sector.sv =====
// Stage 1: hue wrap and split into sector and offset, registered.
// Depends on hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_sector import hsv2rgb_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [HUE_W-1:0]  hue_deg,
    input  wire logic [FRAC_W-1:0] saturation,
    input  wire logic [FRAC_W-1:0] brightness,
    input  wire logic [CHAN_W-1:0] alpha_in,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output sect_t                  out_data
);

    logic     valid_reg;
    sect_t    data_reg;
    sect_t    data_next;
    hue_pos_t pos;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        pos              = hue_split(hue_deg);
        data_next.sector = pos.sector;
        data_next.rem    = pos.rem;
        data_next.sat    = saturation;
        data_next.val    = brightness;
        data_next.alpha  = alpha_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ===== hdl/hsv2rgb_weight.sv =====
// Stage 2: p, q and t weights from saturation and offset, routed per sector.
// Depends on hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_weight import hsv2rgb_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire sect_t in_data,
    output logic       out_valid,
    input  wire logic  out_ready,
    output wgt_t       out_data
);

    logic                        valid_reg;
    wgt_t                        data_reg;
    wgt_t                        data_next;
    logic [REM_W-1:0]            rem_inv;
    logic [FRAC_W+REM_W-1:0]     sat_rem;
    logic [FRAC_W+REM_W-1:0]     sat_inv;
    logic signed [FRAC_W:0]      one_minus_sat;
    logic signed [WGT_W:0]       wp_full;
    logic signed [WGT_W:0]       wq_full;
    logic signed [WGT_W:0]       wt_full;
    logic signed [WGT_W-1:0]     wp;
    logic signed [WGT_W-1:0]     wq;
    logic signed [WGT_W-1:0]     wt;
    logic signed [WGT_W-1:0]     wv;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        rem_inv       = REM_W'(SECTOR_DEG) - in_data.rem;
        sat_rem       = (FRAC_W+REM_W)'(in_data.sat) * (FRAC_W+REM_W)'(in_data.rem);
        sat_inv       = (FRAC_W+REM_W)'(in_data.sat) * (FRAC_W+REM_W)'(rem_inv);
        one_minus_sat = (FRAC_W+1)'(FRAC_ONE) - (FRAC_W+1)'(in_data.sat);
        wp_full       = (WGT_W+1)'(one_minus_sat) * (WGT_W+1)'(SECTOR_DEG);
        wq_full       = (WGT_W+1)'(WGT_ONE) - (WGT_W+1)'(sat_rem);
        wt_full       = (WGT_W+1)'(WGT_ONE) - (WGT_W+1)'(sat_inv);
        wp            = wp_full[WGT_W-1:0];
        wq            = wq_full[WGT_W-1:0];
        wt            = wt_full[WGT_W-1:0];
        wv            = WGT_W'(WGT_ONE);

        data_next.val   = in_data.val;
        data_next.alpha = in_data.alpha;
        case (in_data.sector)
            SECT_RED_YELLOW:
            begin
                data_next.w_red = wv; data_next.w_green = wt; data_next.w_blue = wp;
            end
            SECT_YELLOW_GREEN:
            begin
                data_next.w_red = wq; data_next.w_green = wv; data_next.w_blue = wp;
            end
            SECT_GREEN_CYAN:
            begin
                data_next.w_red = wp; data_next.w_green = wv; data_next.w_blue = wt;
            end
            SECT_CYAN_BLUE:
            begin
                data_next.w_red = wp; data_next.w_green = wq; data_next.w_blue = wv;
            end
            SECT_BLUE_MAGENTA:
            begin
                data_next.w_red = wt; data_next.w_green = wp; data_next.w_blue = wv;
            end
            default:
            begin
                data_next.w_red = wv; data_next.w_green = wp; data_next.w_blue = wq;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ===== hdl/hsv2rgb_product.sv =====
// Stage 3: one value-times-weight multiplier per channel, registered.
// Depends on hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_product import hsv2rgb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire wgt_t in_data,
    output logic      out_valid,
    input  wire logic out_ready,
    output num_t      out_data
);

    localparam int PROD_W = FRAC_W + 1 + WGT_W;

    logic valid_reg;
    num_t data_reg;
    num_t data_next;

    function automatic logic signed [NUM_W-1:0] scale_val(
        input logic [FRAC_W-1:0]       val,
        input logic signed [WGT_W-1:0] w
    );
        logic signed [FRAC_W:0]  sval;
        logic signed [PROD_W-1:0] prod;
        sval = $signed({1'b0, val});
        prod = PROD_W'(sval) * PROD_W'(w);
        return prod[NUM_W-1:0];
    endfunction

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        data_next.n_red   = scale_val(in_data.val, in_data.w_red);
        data_next.n_green = scale_val(in_data.val, in_data.w_green);
        data_next.n_blue  = scale_val(in_data.val, in_data.w_blue);
        data_next.alpha   = in_data.alpha;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ===== hdl/hsv2rgb_scale.sv =====
// Stage 4 and output register: scale each numerator to 0..255 and clamp.
// Depends on hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_scale import hsv2rgb_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire num_t         in_data,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [CHAN_W-1:0] red,
    output logic [CHAN_W-1:0] green,
    output logic [CHAN_W-1:0] blue,
    output logic [CHAN_W-1:0] alpha_out
);

    localparam int SCL_W = NUM_W + 4;
    localparam int QUO_W = SCL_W - SCALE_SHIFT;

    logic              valid_reg;
    logic [CHAN_W-1:0] red_reg;
    logic [CHAN_W-1:0] green_reg;
    logic [CHAN_W-1:0] blue_reg;
    logic [CHAN_W-1:0] alpha_reg;
    logic [CHAN_W-1:0] red_next;
    logic [CHAN_W-1:0] green_next;
    logic [CHAN_W-1:0] blue_next;

    // floor(17 * num / 2^18), zero for non-positive, clamp at full scale
    function automatic logic [CHAN_W-1:0] to_chan(input logic signed [NUM_W-1:0] num);
        logic [SCL_W-1:0] prod;
        logic [QUO_W-1:0] quo;
        logic [CHAN_W-1:0] res;
        prod = SCL_W'(num[NUM_W-2:0]) * SCL_W'(SCALE_MUL);
        quo  = prod[SCL_W-1:SCALE_SHIFT];
        if (num[NUM_W-1] || num == '0)
            res = '0;
        else if (quo > QUO_W'(CHAN_MAX))
            res = CHAN_W'(CHAN_MAX);
        else
            res = quo[CHAN_W-1:0];
        return res;
    endfunction

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        red_next   = to_chan(in_data.n_red);
        green_next = to_chan(in_data.n_green);
        blue_next  = to_chan(in_data.n_blue);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            alpha_reg <= in_data.alpha;
        end
    end

    assign out_valid = valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;
    assign alpha_out = alpha_reg;

endmodule

`default_nettype wire

// ===== hdl/hsv_to_rgb_converter.sv =====
// HSV to RGBA converter, top level: four pipeline stages in a row.
// Depends on hsv2rgb_pkg and the hsv2rgb_sector, _weight, _product, _scale stages.
`default_nettype none

// Converts one HSV pixel (hue in degrees, saturation and brightness as
// fractions of 256, where 256 is full scale) plus an alpha byte into one
// RGBA pixel. Hue 360 reads as 0, hues above 360 wrap once; saturation or
// brightness above full scale clamp each channel into 0..255. Zero
// saturation gives grey at the brightness level. The pipeline has four
// register stages (hue split, sector weights, value multiply, scale and
// clamp), and a result passes through them in that order before it can
// transfer out. A new pixel is taken on every clock: one pixel per
// cycle, sustained, as long as the output side takes results. Each stage
// holds its own valid bit and advances only when its successor can take
// the item, so a stall at the output fills the bubbles upstream first and
// then holds in_ready low; in_ready follows out_ready combinationally
// through the stage chain. No state survives between pixels.

module hsv_to_rgb_converter import hsv2rgb_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [HUE_W-1:0]  hue_deg,
    input  wire logic [FRAC_W-1:0] saturation,
    input  wire logic [FRAC_W-1:0] brightness,
    input  wire logic [CHAN_W-1:0] alpha_in,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [CHAN_W-1:0]      red,
    output logic [CHAN_W-1:0]      green,
    output logic [CHAN_W-1:0]      blue,
    output logic [CHAN_W-1:0]      alpha_out
);

    // Stage-to-stage handshakes and payloads
    logic  sect_valid;
    logic  sect_ready;
    sect_t sect_data;
    logic  wgt_valid;
    logic  wgt_ready;
    wgt_t  wgt_data;
    logic  num_valid;
    logic  num_ready;
    num_t  num_data;

    // Wrap the hue and split it into a 60-degree sector and an offset
    hsv2rgb_sector u_sector (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .hue_deg    (hue_deg),
        .saturation (saturation),
        .brightness (brightness),
        .alpha_in   (alpha_in),
        .out_valid  (sect_valid),
        .out_ready  (sect_ready),
        .out_data   (sect_data)
    );

    // Build the p, q, t weights and route them to red, green, blue
    hsv2rgb_weight u_weight (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sect_valid),
        .in_ready  (sect_ready),
        .in_data   (sect_data),
        .out_valid (wgt_valid),
        .out_ready (wgt_ready),
        .out_data  (wgt_data)
    );

    // Multiply each weight by the brightness
    hsv2rgb_product u_product (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (wgt_valid),
        .in_ready  (wgt_ready),
        .in_data   (wgt_data),
        .out_valid (num_valid),
        .out_ready (num_ready),
        .out_data  (num_data)
    );

    // Scale to 8-bit channels, clamp, and hold the result for transfer
    hsv2rgb_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (num_valid),
        .in_ready  (num_ready),
        .in_data   (num_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .alpha_out (alpha_out)
    );

endmodule

`default_nettype wire

// ===== hdl/hsv2rgb_checker.sv =====
// Port-level checks on the converter, bound onto the top level.
// Depends on assert_macros.svh and the top level's port names.
`default_nettype none
`include "assert_macros.svh"

module hsv2rgb_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] red,
    input wire logic [7:0] green,
    input wire logic [7:0] blue,
    input wire logic [7:0] alpha_out
);

    localparam int DEPTH = 4;

    logic [2:0]  pending_reg;
    logic [2:0]  pending_next;
    logic        in_xfer;
    logic        out_xfer;
    logic [31:0] out_pixel;

    assign in_xfer   = in_valid && in_ready;
    assign out_xfer  = out_valid && out_ready;
    assign out_pixel = {red, green, blue, alpha_out};

    // Count items taken in and not yet delivered
    always_comb
    begin
        pending_next = pending_reg;
        if (in_xfer && !out_xfer)
            pending_next = pending_reg + 3'd1;
        else if (out_xfer && !in_xfer)
            pending_next = pending_reg - 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_next;
    end

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_pixel))
    `ASSERT_IMPLY(a_empty_ready, clk, rst_n, !out_valid, in_ready)
    `ASSERT_IMPLY(a_no_invent, clk, rst_n, out_valid, pending_reg != 3'd0)
    `ASSERT_ALWAYS(a_depth, clk, rst_n, pending_reg <= 3'(DEPTH))

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_checker (.*);

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for hsv_to_rgb_converter: random HSV pixels in, RGBA pixels checked
// against an exact integer model of the conversion. Depends on hsv2rgb_pkg and the converter RTL.
module testbench;
    import hsv2rgb_pkg::*;

    // Share of cycles in which each side holds off, in percent
    localparam int IDLE_PCT     = 31;
    // Window of transfers during which neither side idles
    localparam int CALM_FROM    = 300;
    localparam int CALM_TO      = 450;
    localparam int RANDOM_ITEMS = 800;
    // Cycles to let the four-stage pipeline drain at the end
    localparam int DRAIN_CYCLES = 12;

    // Exact arithmetic over the common denominator 256 * 256 * 60
    localparam longint FULL_TURN = 360;
    localparam longint DEG_PER   = 60;
    localparam longint UNIT      = 256;
    localparam longint LEVEL_TOP = 255;
    localparam longint DENOM     = UNIT * UNIT * DEG_PER;

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [FRAC_W-1:0] sat;
        logic [FRAC_W-1:0] val;
        logic [CHAN_W-1:0] alpha;
    } hsv_pixel_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
    } rgba_pixel_t;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              in_valid   = 1'b0;
    logic              in_ready;
    logic [HUE_W-1:0]  hue_deg    = '0;
    logic [FRAC_W-1:0] saturation = '0;
    logic [FRAC_W-1:0] brightness = '0;
    logic [CHAN_W-1:0] alpha_in   = '0;
    logic              out_valid;
    logic              out_ready  = 1'b0;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha_out;

    hsv_pixel_t  pending_pixels[$];
    rgba_pixel_t expected_pixels[$];
    int          mismatch_count = 0;
    int          sent_count     = 0;
    int          taken_count    = 0;

    hsv_to_rgb_converter i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .hue_deg    (hue_deg),
        .saturation (saturation),
        .brightness (brightness),
        .alpha_in   (alpha_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .alpha_out  (alpha_out)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Floor of 255 times a numerator over DENOM; clamp negatives to 0 and overshoot to 255
    function automatic logic [CHAN_W-1:0] to_level(input longint num);
        longint scaled;
        if (num <= 0)
            return '0;
        scaled = (num * LEVEL_TOP) / DENOM;
        if (scaled > LEVEL_TOP)
            scaled = LEVEL_TOP;
        return CHAN_W'(scaled);
    endfunction

    // Expected RGBA pixel for one HSV pixel
    function automatic rgba_pixel_t predict_rgba(input hsv_pixel_t px);
        longint      h;
        longint      s;
        longint      v;
        longint      rem;
        longint      n_full;
        longint      n_low;
        longint      n_fall;
        longint      n_rise;
        longint      n_r;
        longint      n_g;
        longint      n_b;
        sector_t     sect;
        rgba_pixel_t res;
        h = px.hue;
        s = px.sat;
        v = px.val;
        n_full = v * UNIT * DEG_PER;
        if (s == 0)
        begin
            // Grey: every channel sits at the brightness level
            n_r = n_full;
            n_g = n_full;
            n_b = n_full;
        end
        else
        begin
            // Wrap once: 360 reads as 0, larger hues land in 1..151
            if (h >= FULL_TURN)
                h = h - FULL_TURN;
            sect   = sector_t'(3'(h / DEG_PER));
            rem    = h % DEG_PER;
            n_low  = v * (UNIT - s) * DEG_PER;
            n_fall = v * (UNIT * DEG_PER - s * rem);
            n_rise = v * (UNIT * DEG_PER - s * (DEG_PER - rem));
            case (sect)
                SECT_RED_YELLOW:
                begin
                    n_r = n_full; n_g = n_rise; n_b = n_low;
                end
                SECT_YELLOW_GREEN:
                begin
                    n_r = n_fall; n_g = n_full; n_b = n_low;
                end
                SECT_GREEN_CYAN:
                begin
                    n_r = n_low;  n_g = n_full; n_b = n_rise;
                end
                SECT_CYAN_BLUE:
                begin
                    n_r = n_low;  n_g = n_fall; n_b = n_full;
                end
                SECT_BLUE_MAGENTA:
                begin
                    n_r = n_rise; n_g = n_low;  n_b = n_full;
                end
                default:
                begin
                    n_r = n_full; n_g = n_low;  n_b = n_fall;
                end
            endcase
        end
        res.red   = to_level(n_r);
        res.green = to_level(n_g);
        res.blue  = to_level(n_b);
        res.alpha = px.alpha;
        return res;
    endfunction

    task automatic queue_pixel(input int h, input int s, input int v, input int a);
        hsv_pixel_t px;
        px.hue   = HUE_W'(h);
        px.sat   = FRAC_W'(s);
        px.val   = FRAC_W'(v);
        px.alpha = CHAN_W'(a);
        pending_pixels.push_back(px);
    endtask

    task automatic check_channel(input string label, input logic [CHAN_W-1:0] want,
                                 input logic [CHAN_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, label, want, got);
            mismatch_count++;
        end
    endtask

    // Driver: advance to the next pending pixel once the current transfer completes.
    // Hold valid and payload steady while the converter stalls.
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        hsv_pixel_t nxt;
        bit         calm;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            hue_deg    <= '0;
            saturation <= '0;
            brightness <= '0;
            alpha_in   <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                sent_count++;
            if (!in_valid || in_ready)
            begin
                calm = (sent_count >= CALM_FROM) && (sent_count < CALM_TO);
                if (pending_pixels.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    nxt = pending_pixels.pop_front();
                    in_valid   <= 1'b1;
                    hue_deg    <= nxt.hue;
                    saturation <= nxt.sat;
                    brightness <= nxt.val;
                    alpha_in   <= nxt.alpha;
                end
                else
                begin
                    // Drop valid for an idle cycle or because the stimulus ran out
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: predict on every input transfer, check every output transfer.
    // Push before pop so that a same-edge pair still compares against the oldest entry.
    always @(posedge clk or negedge rst_n)
    begin : check_proc
        hsv_pixel_t  seen;
        rgba_pixel_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                seen.hue   = hue_deg;
                seen.sat   = saturation;
                seen.val   = brightness;
                seen.alpha = alpha_in;
                expected_pixels.push_back(predict_rgba(seen));
            end
            if (out_valid && out_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $display("%0t ns: unexpected pixel r=%0d g=%0d b=%0d a=%0d",
                             $time, red, green, blue, alpha_out);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    check_channel("red",   want.red,   red);
                    check_channel("green", want.green, green);
                    check_channel("blue",  want.blue,  blue);
                    check_channel("alpha", want.alpha, alpha_out);
                end
                taken_count++;
            end
            // Stall the output at random, except inside the calm window
            out_ready <= ((taken_count >= CALM_FROM) && (taken_count < CALM_TO))
                         || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    initial
    begin : stimulus_proc
        int pick;
        // Grey pixels: zero saturation, including out-of-range hue and brightness
        queue_pixel(0,   0,   0,   0);
        queue_pixel(200, 0,   256, 255);
        queue_pixel(511, 0,   511, 170);
        // Both edges of every sector at full saturation and brightness
        queue_pixel(0,   256, 256, 1);
        queue_pixel(59,  256, 256, 2);
        queue_pixel(60,  256, 256, 4);
        queue_pixel(119, 256, 256, 8);
        queue_pixel(120, 256, 256, 16);
        queue_pixel(179, 256, 256, 32);
        queue_pixel(180, 256, 256, 64);
        queue_pixel(239, 256, 256, 128);
        queue_pixel(240, 256, 256, 254);
        queue_pixel(299, 256, 256, 253);
        queue_pixel(300, 256, 256, 251);
        queue_pixel(359, 256, 256, 247);
        // Hue of a full turn reads as zero; larger hues wrap once
        queue_pixel(360, 256, 256, 239);
        queue_pixel(361, 200, 256, 223);
        queue_pixel(511, 256, 256, 191);
        // Saturation past full scale drives terms negative
        queue_pixel(30,  511, 256, 127);
        queue_pixel(200, 257, 200, 85);
        // Brightness past full scale clips at 255
        queue_pixel(90,  128, 511, 42);
        queue_pixel(330, 1,   511, 21);
        // Black at full saturation and the smallest nonzero inputs
        queue_pixel(45,  256, 0,   10);
        queue_pixel(10,  1,   1,   5);

        // Mostly well-formed pixels, some grey, some with hue, saturation and brightness out of range
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                queue_pixel($urandom_range(0, 360), $urandom_range(0, 256),
                            $urandom_range(0, 256), $urandom_range(0, 255));
            else if (pick < 80)
                queue_pixel($urandom_range(0, 511), 0,
                            $urandom_range(0, 511), $urandom_range(0, 255));
            else
                queue_pixel($urandom_range(0, 511), $urandom_range(0, 511),
                            $urandom_range(0, 511), $urandom_range(0, 255));
        end

        // Hold reset, then release it on a rising edge
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every pixel has transferred in and every result has come back
        do
            @(posedge clk);
        while (pending_pixels.size() != 0 || in_valid || expected_pixels.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_pixels.size() != 0)
        begin
            $display("%0t ns: %0d pixels never came out", $time, expected_pixels.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog: a healthy run finishes in a small fraction of this
    initial
    begin
        #400000;
        $display("tb: failure");
        $finish;
    end

endmodule
